// ===== hw/rtl/m2d_pkg.sv =====
// shared types and constants for the minifloat to binary64 converter
package m2d_pkg;

   localparam int unsigned MAX_MANTISSA_BITS = 52;
   localparam int unsigned MAX_EXPONENT_BITS = 11;

   typedef enum logic [2:0] {
      CLASS_ZERO = 3'd0,
      CLASS_SUB  = 3'd1,
      CLASS_NORM = 3'd2,
      CLASS_INF  = 3'd3,
      CLASS_NAN  = 3'd4
   } value_class_type;

   localparam logic [3:0] CFG_EXPONENT_WIDTH = 4'd0;
   localparam logic [3:0] CFG_MANTISSA_WIDTH = 4'd1;

   localparam logic [3:0] EW_RESET = 4'd8;
   localparam logic [5:0] MW_RESET = 6'd23;

   localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;

   // clamped format widths handed to the datapath
   typedef struct packed {
      logic [3:0] ew;
      logic [5:0] mw;
   } fmt_type;

endpackage

// ===== hw/rtl/m2d_csr.sv =====
// width registers with clamping to the legal ranges
module m2d_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [3:0]       csr_index,
   input  logic [5:0]       csr_wdata,
   output m2d_pkg::fmt_type fmt
);
   import m2d_pkg::*;

   logic [3:0] ew_ff, ew_in;
   logic [5:0] mw_ff, mw_in;

   // register writes
   always_comb begin
      ew_in = ew_ff;
      mw_in = mw_ff;
      if (csr_we && csr_index == CFG_EXPONENT_WIDTH) ew_in = csr_wdata[3:0];
      if (csr_we && csr_index == CFG_MANTISSA_WIDTH) mw_in = csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ew_ff <= EW_RESET;
         mw_ff <= MW_RESET;
      end else begin
         ew_ff <= ew_in;
         mw_ff <= mw_in;
      end
   end

   // clamp on use
   always_comb begin
      fmt.ew = (ew_ff < 4'd2) ? 4'd2 : ((ew_ff > 4'd11) ? 4'd11 : ew_ff);
      fmt.mw = (mw_ff < 6'd1) ? 6'd1 : ((mw_ff > 6'd52) ? 6'd52 : mw_ff);
   end
endmodule

// ===== hw/rtl/m2d_decode.sv =====
// combinational classify, leading-zero count and rebias
module m2d_decode (
   input  m2d_pkg::fmt_type         fmt,
   input  logic                     sign_bit,
   input  logic [10:0]              exponent_field,
   input  logic [51:0]              mantissa_field,
   output m2d_pkg::value_class_type value_class,
   output logic [63:0]              double_bits
);
   import m2d_pkg::*;

   logic [10:0] emask, e;
   logic [51:0] fmask, f, fn;
   logic [5:0]  p;
   logic [10:0] bias;
   logic signed [13:0] x;
   logic signed [13:0] s;
   logic [5:0]  sc;
   logic [63:0] sgn;

   always_comb begin
      emask = 11'((12'd1 << fmt.ew) - 12'd1);
      e     = exponent_field & emask;
      fmask = 52'((53'd1 << fmt.mw) - 53'd1);
      f     = mantissa_field & fmask;
      bias  = 11'((12'd1 << (fmt.ew - 4'd1)) - 12'd1);
      sgn   = {sign_bit, 63'd0};
      // msb position of the fraction
      p = 6'd0;
      for (int i = 0; i < 52; i++) begin
         if (f[i]) p = 6'(i);
      end
      x  = 14'(p) + 14'sd1 - 14'(bias) - 14'(fmt.mw);
      s  = 14'sd1075 - 14'(bias) - 14'(fmt.mw);
      sc = (s < 0) ? 6'd0 : ((s > 14'sd63) ? 6'd63 : s[5:0]);
      fn = 52'(({12'd0, f} ^ (64'd1 << p)) << (6'd52 - p));
      value_class = CLASS_NORM;
      double_bits = 64'd0;
      if (e == emask) begin
         if (f == 52'd0) begin
            value_class = CLASS_INF;
            double_bits = sgn | {1'b0, 11'h7FF, 52'd0};
         end else begin
            value_class = CLASS_NAN;
            double_bits = QNAN_BITS;
         end
      end else if (e == 11'd0) begin
         if (f == 52'd0) begin
            value_class = CLASS_ZERO;
            double_bits = sgn;
         end else begin
            value_class = CLASS_SUB;
            if (x >= -14'sd1022) begin
               double_bits = sgn | {1'b0, 11'(x + 14'sd1023), fn};
            end else begin
               double_bits = sgn | {12'd0, 52'({12'd0, f} << sc)};
            end
         end
      end else begin
         value_class = CLASS_NORM;
         double_bits = sgn | {1'b0, 11'(14'(e) - 14'(bias) + 14'sd1023),
                              52'(f << (6'd52 - fmt.mw))};
      end
   end
endmodule

// ===== hw/rtl/minifloat_to_double_converter.sv =====
// top level: minifloat to binary64 converter with stream channels
// A source value (sign, exponent field, fraction field) arrives on the req_
// channel; the class and binary64 pattern leave on the rsp_ channel.
// The csr_ port sets the exponent and fraction widths (index 0 and 1); the
// user writes it only while the block is idle; the block does not enforce this.
// An item is registered on its input transfer, decoded by one pass of
// combinational logic and registered again in the result register, from
// which it leaves on the rsp_ channel. One item is accepted every cycle while
// the receiver does not stall; the rate is set by the single decode pass
// between the two register stages.
// When the receiver stalls the result register holds and the input
// register fills; req_tready drops only while both are full and
// rsp_tready is low.
// Reset (synchronous, active high) empties both stages and sets the
// widths to 8 and 23 bits.
module minifloat_to_double_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // sign_bit [0], exponent_field [11:1], mantissa_field [63:12]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // value_class [2:0], double_bits [66:3], zero fill above
   output logic [71:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [3:0]  csr_index,
   input  logic [5:0]  csr_wdata
);
   import m2d_pkg::*;

   localparam int unsigned IN_W = 1 + MAX_EXPONENT_BITS + MAX_MANTISSA_BITS;

   fmt_type fmt;
   logic [IN_W-1:0] in_data_ff, in_data_in;
   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic [66:0] out_data_ff, out_data_in;
   value_class_type cls;
   logic [63:0] dbits;
   logic advance;

   m2d_csr u_csr (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata, .fmt
   );

   m2d_decode u_decode (
      .fmt,
      .sign_bit       (in_data_ff[0]),
      .exponent_field (in_data_ff[11:1]),
      .mantissa_field (in_data_ff[63:12]),
      .value_class    (cls),
      .double_bits    (dbits)
   );

   // stage handshake
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_valid_ff && rsp_tready) out_valid_in = 1'b0;
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = {dbits, cls};
         in_valid_in  = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_tdata[IN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_data_ff};

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   // no accept when both stages are full and stalled
   a_full: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_tready |-> !req_tready)
      else $error("accept while full");
   // an item that advances from the input stage reaches the output stage
   a_flow: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("lost item");
endmodule

// ===== test/tb_minifloat_to_double_converter.sv =====
// testbench for the minifloat to binary64 converter: stream stimulus, checks against a predictor
`timescale 1ns / 100ps

module tb_minifloat_to_double_converter;
   import m2d_pkg::*;

   localparam int LIMIT_CYCLES = 400000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        csr_we;
   logic [3:0]  csr_index;
   logic [5:0]  csr_wdata;

   typedef struct packed {
      logic [2:0]  cls;
      logic [63:0] bits;
   } decoded_type;

   decoded_type pending_decodes[$];
   logic [3:0]  exp_width_reg;
   logic [5:0]  man_width_reg;
   int          mismatches;
   int          decoded_count;
   int          cycle_count;
   int          class_seen[5];
   logic        stall_mode;

   minifloat_to_double_converter uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // binary64 image of one source value under the current widths
   function automatic decoded_type decode_minifloat(logic s, logic [10:0] ef, logic [51:0] mf);
      decoded_type r;
      int ew, mw, bias, p, x, sh;
      logic [63:0] sgn, emask, e, f, frac;
      ew = (exp_width_reg < 2) ? 2 : (exp_width_reg > 11) ? 11 : int'(exp_width_reg);
      mw = (man_width_reg < 1) ? 1 : (man_width_reg > 52) ? 52 : int'(man_width_reg);
      sgn = {s, 63'd0};
      emask = (64'd1 << ew) - 1;
      e = {53'd0, ef} & emask;
      f = {12'd0, mf} & ((64'd1 << mw) - 1);
      bias = (1 << (ew - 1)) - 1;
      if (e == emask) begin
         if (f == 0) begin
            r.cls = CLASS_INF;
            r.bits = sgn | {1'b0, 11'h7FF, 52'd0};
         end else begin
            r.cls = CLASS_NAN;
            r.bits = QNAN_BITS;
         end
      end else if (e == 0) begin
         if (f == 0) begin
            r.cls = CLASS_ZERO;
            r.bits = sgn;
         end else begin
            p = 0;
            for (int i = 0; i < 64; i++) if (f[i]) p = i;
            x = p + 1 - bias - mw;
            r.cls = CLASS_SUB;
            if (x >= -1022) begin
               frac = (f ^ (64'd1 << p)) << (52 - p);
               r.bits = sgn | (64'(x + 1023) << 52) | frac;
            end else begin
               sh = 1075 - bias - mw;
               if (sh < 0) sh = 0;
               if (sh > 63) sh = 63;
               r.bits = sgn | ((f << sh) & ((64'd1 << 52) - 1));
            end
         end
      end else begin
         x = int'(e) - bias;
         r.cls = CLASS_NORM;
         r.bits = sgn | (64'(x + 1023) << 52) | (f << (52 - mw));
      end
      return r;
   endfunction

   // one input transfer, with its prediction queued on acceptance; valid stays high
   task automatic send_value(logic s, logic [10:0] ef, logic [51:0] mf);
      decoded_type d;
      req_tvalid <= 1'b1;
      req_tdata  <= {mf, ef, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      d = decode_minifloat(s, ef, mf);
      pending_decodes.push_back(d);
      class_seen[d.cls]++;
      @(negedge clock);
   endtask

   // burst of n random values, specials optional; keeps valid high inside a burst
   task automatic send_burst(int n, bit allow_special);
      logic [10:0] ef;
      logic [51:0] mf;
      int k;
      for (int i = 0; i < n; i++) begin
         mf = 52'({$urandom, $urandom});
         ef = 11'($urandom);
         k = $urandom_range(0, 9);
         if (allow_special && k == 0) ef = '0;
         if (allow_special && k == 1) ef = '1;
         if (allow_special && k == 2) mf = '0;
         if (k == 3) mf = 52'd1 << $urandom_range(0, 51);
         send_value(1'($urandom_range(0, 1)), ef, mf);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_decodes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [3:0] idx, logic [5:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      if (idx == CFG_EXPONENT_WIDTH) exp_width_reg = val[3:0];
      else if (idx == CFG_MANTISSA_WIDTH) man_width_reg = val;
   endtask

   task automatic set_format(logic [3:0] ew, logic [5:0] mw);
      wait_drained();
      write_reg(CFG_EXPONENT_WIDTH, {2'b00, ew});
      write_reg(CFG_MANTISSA_WIDTH, mw);
      csr_we <= 1'b0;
   endtask

   // directed corners at the reset format and at the extremes
   task automatic test_directed();
      send_value(1'b0, 11'd0, 52'd0);
      send_value(1'b1, 11'd0, 52'd0);
      send_value(1'b0, 11'd0, 52'd1);
      send_value(1'b1, 11'd0, 52'h7FFFFF);
      send_value(1'b0, 11'd1, 52'd0);
      send_value(1'b1, 11'hFE, 52'h7FFFFF);
      send_value(1'b0, 11'hFF, 52'd0);
      send_value(1'b1, 11'hFF, 52'd0);
      send_value(1'b1, 11'hFF, 52'd1);
      send_value(1'b0, 11'h7FF, {52{1'b1}});
      send_value(1'b1, 11'h700, 52'hF_FFFF_FF80_0000);
      set_format(4'd11, 6'd52);
      send_value(1'b0, 11'd0, 52'd1);
      send_value(1'b1, 11'd0, {52{1'b1}});
      send_value(1'b0, 11'h7FE, {52{1'b1}});
      send_value(1'b1, 11'h7FF, 52'd0);
      send_value(1'b0, 11'h7FF, 52'd8);
      set_format(4'd2, 6'd1);
      send_value(1'b0, 11'd0, 52'd1);
      send_value(1'b1, 11'd1, 52'd1);
      send_value(1'b0, 11'd2, 52'd0);
      send_value(1'b1, 11'd3, 52'd0);
      send_value(1'b0, 11'd3, 52'd1);
      // out-of-range widths get clamped
      set_format(4'd0, 6'd0);
      send_value(1'b1, 11'd0, 52'd1);
      set_format(4'd15, 6'd63);
      send_value(1'b0, 11'd0, 52'd3);
   endtask

   // random formats, bursts and gaps
   task automatic test_random();
      int sent;
      int next_fmt;
      sent = 0;
      next_fmt = 0;
      while (sent < 1300) begin
         if (sent >= next_fmt) begin
            set_format(4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)));
            next_fmt += 100;
         end
         if ($urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         if ($urandom_range(0, 40) == 0) wait_drained();
         begin
            int n;
            n = $urandom_range(1, 16);
            send_burst(n, 1'b1);
            sent += n;
         end
      end
   endtask

   // receiver stall pattern: alternate between free-running and random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_mode <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
         rsp_tready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      decoded_type want;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (pending_decodes.size() == 0) begin
               $display("%0t unexpected transfer: actual %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = pending_decodes.pop_front();
               decoded_count++;
               if (rsp_tdata[2:0] !== want.cls) begin
                  $display("%0t class mismatch: expected %0d actual %0d",
                           $time, want.cls, rsp_tdata[2:0]);
                  mismatches++;
               end
               if (rsp_tdata[66:3] !== want.bits) begin
                  $display("%0t bits mismatch: expected %h actual %h",
                           $time, want.bits, rsp_tdata[66:3]);
                  mismatches++;
               end
            end
         end
         if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      rsp_tready = 1'b0;
      stall_mode = 1'b0;
      mismatches = 0;
      decoded_count = 0;
      cycle_count = 0;
      exp_width_reg = EW_RESET;
      man_width_reg = MW_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random();
      set_format(4'd8, 6'd23);
      wait_drained();
      $display("checked %0d results: zero %0d, subnormal %0d, normal %0d, inf %0d, nan %0d",
               decoded_count, class_seen[0], class_seen[1], class_seen[2],
               class_seen[3], class_seen[4]);
      if (mismatches == 0 && pending_decodes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/m2d_pkg.sv
hw/rtl/m2d_csr.sv
hw/rtl/m2d_decode.sv
hw/rtl/minifloat_to_double_converter.sv
test/tb_minifloat_to_double_converter.sv
